// ===== sv/pipp_pkg.sv =====
// Package with shared types and constants of the point-in-polygon parity block.
`timescale 1ns / 1ps
`default_nettype none

package pipp_pkg;

  // Default coordinate width: signed 16.8 fixed point.
  localparam int COORD_BITS_DEF = 24;

  // Default depth of the queue between the front and the back.
  localparam int TOK_DEPTH = 4;

  // Work left for the back after an edge has been classified.
  typedef struct packed {
    logic toggle;
    logic last;
  } pipp_tok_t;

endpackage

`default_nettype wire

// ===== sv/pipp_front.sv =====
// Front: takes edges, forms differences and cross products, and classifies each edge.
`timescale 1ns / 1ps
`default_nettype none

module pipp_front #(
  parameter int COORD_BITS = pipp_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         skip_edge,
  input  wire logic                         last_edge,
  input  wire logic                         queue_full,
  output logic                              tok_wr,
  output pipp_pkg::pipp_tok_t               tok
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int MSB = COORD_BITS - 1;

  logic advance;
  logic straddle;

  // Stage one: differences and classification.
  logic                 s1_valid;
  logic signed [DW-1:0] s1_dyp;
  logic signed [DW-1:0] s1_dx;
  logic signed [DW-1:0] s1_dxp;
  logic signed [DW-1:0] s1_dy;
  logic                 s1_up;
  logic                 s1_hit;
  logic                 s1_last;

  // Stage two: the two cross products.
  logic                 s2_valid;
  logic signed [PW-1:0] s2_pa;
  logic signed [PW-1:0] s2_pb;
  logic                 s2_up;
  logic                 s2_hit;
  logic                 s2_last;

  // The whole pipeline moves together; it only halts when its last stage is
  // occupied and the queue cannot take the token.
  assign advance = !s2_valid || !queue_full;
  assign full    = !advance;

  // Half-open rule: one endpoint strictly below the point, the other at or above.
  assign straddle = ((start_y < point_y) && (end_y >= point_y)) ||
                    ((end_y < point_y) && (start_y >= point_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= push;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_dyp  <= {point_y[MSB], point_y} - {start_y[MSB], start_y};
      s1_dx   <= {end_x[MSB], end_x} - {start_x[MSB], start_x};
      s1_dxp  <= {point_x[MSB], point_x} - {start_x[MSB], start_x};
      s1_dy   <= {end_y[MSB], end_y} - {start_y[MSB], start_y};
      s1_up   <= end_y > start_y;
      s1_hit  <= !skip_edge && straddle;
      s1_last <= last_edge;
      s2_pa   <= s1_dyp * s1_dx;
      s2_pb   <= s1_dxp * s1_dy;
      s2_up   <= s1_up;
      s2_hit  <= s1_hit;
      s2_last <= s1_last;
    end
  end

  // For an upward edge the crossing lies left when pa < pb; a downward edge
  // has a negative divisor, so the inequality turns round.
  assign tok_wr     = s2_valid && !queue_full;
  assign tok.toggle = s2_hit && (s2_up ? (s2_pa < s2_pb) : (s2_pb < s2_pa));
  assign tok.last   = s2_last;

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    s2_valid && !advance |=> s2_valid && $stable(s2_pa) && $stable(s2_last))
    else $error("front stage two lost its edge during a stall");

endmodule

`default_nettype wire

// ===== sv/pipp_queue.sv =====
// Short token queue that decouples the front from the back.
`timescale 1ns / 1ps
`default_nettype none

module pipp_queue #(
  parameter int DEPTH = pipp_pkg::TOK_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr,
  input  wire pipp_pkg::pipp_tok_t  wr_tok,
  input  wire logic                 rd,
  output pipp_pkg::pipp_tok_t       rd_tok,
  output logic                      full,
  output logic                      empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pipp_pkg::pipp_tok_t slots [DEPTH];
  logic [IW-1:0] wr_ptr;
  logic [IW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full   = count == CW'(DEPTH);
  assign empty  = count == '0;
  assign rd_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("token written into a full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    !(rd && empty))
    else $error("token read from an empty queue");

endmodule

`default_nettype wire

// ===== sv/pipp_back.sv =====
// Back: accumulates crossing parity and holds the result for the receiver.
`timescale 1ns / 1ps
`default_nettype none

module pipp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                tok_empty,
  input  wire pipp_pkg::pipp_tok_t tok,
  output logic                     take,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     inside_res
);

  logic crossing_parity;
  logic parity_next;
  logic out_valid;
  logic out_free;

  assign empty       = !out_valid;
  assign out_free    = !out_valid || pop;
  // A token that closes a polygon needs the result register; others never wait.
  assign take        = !tok_empty && (!tok.last || out_free);
  assign parity_next = crossing_parity ^ tok.toggle;

  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_parity <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        crossing_parity <= tok.last ? 1'b0 : parity_next;
        if (tok.last) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && tok.last) begin
      inside_res <= parity_next;
    end
  end

  a_parity_cleared : assert property (@(posedge clk) disable iff (rst)
    take && tok.last |=> crossing_parity == 1'b0 && out_valid)
    else $error("parity not cleared after a polygon was closed");

endmodule

`default_nettype wire

// ===== sv/point_in_polygon_parity_top.sv =====
// Top level of the even-odd point-in-polygon block.
//
// Edges arrive on a queue-style channel: an edge is transferred at a rising
// edge of clk with push high and full low. Each edge carries the query point,
// both endpoints, a skip flag and a last flag. One edge is taken every cycle
// while the receiver keeps up.
// A result exists only for an edge marked last: inside_res is valid while
// empty is low and is transferred at a rising edge with pop high.
// The result of a last edge passes through the difference stage, the
// multiplier stage and the token queue read by the parity accumulator,
// which registers it for the receiver.
// When the receiver stalls, the result register holds, the back keeps
// folding non-final edges into the parity, and the token queue fills; full
// rises only once the queue is full and the front's last stage holds an
// edge that it cannot hand on.
// Synchronous reset clears the parity, the queue and all valid flags; the
// block is ready in the cycle after reset falls.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_parity_top #(
  parameter int COORD_BITS  = pipp_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = pipp_pkg::TOK_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  input  wire logic                         skip_edge,
  input  wire logic                         last_edge,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              inside_res
);

  pipp_pkg::pipp_tok_t wr_tok;
  pipp_pkg::pipp_tok_t rd_tok;
  logic tok_wr;
  logic tok_rd;
  logic queue_full;
  logic queue_empty;

  pipp_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .skip_edge (skip_edge),
    .last_edge (last_edge),
    .queue_full(queue_full),
    .tok_wr    (tok_wr),
    .tok       (wr_tok)
  );

  pipp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (tok_wr),
    .wr_tok(wr_tok),
    .rd    (tok_rd),
    .rd_tok(rd_tok),
    .full  (queue_full),
    .empty (queue_empty)
  );

  pipp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_empty (queue_empty),
    .tok       (rd_tok),
    .take      (tok_rd),
    .empty     (empty),
    .pop       (pop),
    .inside_res(inside_res)
  );

endmodule

`default_nettype wire

// ===== dv/point_in_polygon_parity_top_tb.sv =====
// Self-checking testbench for the even-odd point-in-polygon parity block.
`timescale 1ns / 1ps

module point_in_polygon_parity_top_tb;

  localparam int CW        = pipp_pkg::COORD_BITS_DEF;
  localparam int N_RANDOM  = 1100;
  localparam int TAIL_WAIT = 12;
  localparam int LIMIT     = 500000;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam coord_t ONE  = 256;
  localparam coord_t TWO  = 512;

  typedef enum int {SC_GRID, SC_NEAR, SC_WIDE, SC_FULL} coord_scale_e;
  typedef enum int {POP_ALWAYS, POP_COIN, POP_RARE, POP_HOLD} pop_mode_e;

  typedef struct {
    coord_t px, py, x0, y0, x1, y1;
    bit     skip;
    bit     last;
    bit     typed;      // result of this row is written in the table
    bit     typed_res;
  } edge_t;

  logic   clk  = 1'b0;
  logic   rst  = 1'b1;
  logic   push = 1'b0;
  logic   pop  = 1'b0;
  edge_t  cur_edge = '{default: '0};
  logic   full, empty, inside_res;

  bit        parity_acc = 1'b0;
  bit        inside_expect_q[$];
  edge_t     edge_table[$];
  int        err_cnt      = 0;
  int        edge_cnt     = 0;
  int        result_cnt   = 0;
  int        toggle_cnt   = 0;
  int        cycle_cnt    = 0;
  int        burst_left   = 0;
  int        pop_span     = 0;
  pop_mode_e pop_mode     = POP_ALWAYS;

  point_in_polygon_parity_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_x   (cur_edge.px),
    .point_y   (cur_edge.py),
    .start_x   (cur_edge.x0),
    .start_y   (cur_edge.y0),
    .end_x     (cur_edge.x1),
    .end_y     (cur_edge.y1),
    .skip_edge (cur_edge.skip),
    .last_edge (cur_edge.last),
    .empty     (empty),
    .pop       (pop),
    .inside_res(inside_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("point_in_polygon_parity_top regression: fail");
      $finish;
    end
  end

  // True when the edge straddles the point's y and crosses strictly left of
  // its x. The division is avoided by comparing cross products, with the
  // sense flipped for a downward edge.
  function automatic bit edge_toggles(edge_t e);
    logic signed [CW+1:0]   rise, run, ry, rx;
    logic signed [2*CW+3:0] lhs, rhs;
    if (!((e.y0 < e.py && e.y1 >= e.py) || (e.y1 < e.py && e.y0 >= e.py)))
      return 1'b0;
    rise = e.y1 - e.y0;
    run  = e.x1 - e.x0;
    ry   = e.py - e.y0;
    rx   = e.px - e.x0;
    lhs  = ry * run;
    rhs  = rx * rise;
    return (rise > 0) ? (lhs < rhs) : (rhs < lhs);
  endfunction

  function automatic coord_t rand_coord(coord_scale_e sc);
    logic [31:0] r;
    r = $urandom();
    case (sc)
      SC_GRID: return coord_t'($urandom_range(0, 8) - 4);
      SC_NEAR: return coord_t'($urandom_range(0, 4096) - 2048);
      SC_WIDE: return coord_t'($urandom_range(0, 2097152) - 1048576);
      default: return r[CW-1:0];
    endcase
  endfunction

  // Scoreboard: predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (push && !full) begin
        if (!cur_edge.skip && edge_toggles(cur_edge)) begin
          parity_acc = ~parity_acc;
          toggle_cnt++;
        end
        if (cur_edge.last) begin
          inside_expect_q.push_back(cur_edge.typed ? cur_edge.typed_res : parity_acc);
          parity_acc = 1'b0;
        end
      end
      if (pop && !empty) begin
        if (inside_expect_q.size() == 0) begin
          $error("inside_res transfer with no result expected (actual %0b)", inside_res);
          err_cnt++;
        end else begin
          want = inside_expect_q.pop_front();
          result_cnt++;
          if (inside_res !== want) begin
            $error("inside_res mismatch: expected %0b, actual %0b", want, inside_res);
            err_cnt++;
          end
        end
      end
    end
  end

  // The receiver stalls on a pattern of its own, switching mode after random spans.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_span == 0) begin
        pop_mode = pop_mode_e'($urandom_range(0, 3));
        pop_span = $urandom_range(4, 60);
      end
      pop_span--;
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_COIN:   pop <= 1'($urandom_range(0, 1));
        POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
        default:    pop <= 1'b0;
      endcase
    end
  end

  task automatic add_row(coord_t px, coord_t py, coord_t x0, coord_t y0, coord_t x1,
                         coord_t y1, bit skip, bit last, bit typed = 0, bit typed_res = 0);
    edge_table.push_back('{px, py, x0, y0, x1, y1, skip, last, typed, typed_res});
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_edge(edge_t e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cur_edge <= e;
    push     <= 1'b1;
    do @(posedge clk); while (full);
    @(negedge clk);
    edge_cnt++;
  endtask

  task automatic send_polygon();
    coord_t       vx[8], vy[8];
    edge_t        e;
    int           n;
    coord_scale_e sc;
    sc = coord_scale_e'($urandom_range(0, 3));
    n  = $urandom_range(3, 8);
    for (int i = 0; i < n; i++) begin
      vx[i] = rand_coord(sc);
      vy[i] = rand_coord(sc);
    end
    e = '{default: '0};
    e.px = rand_coord(sc);
    e.py = rand_coord(sc);
    // Put the point on a vertex's level now and then to reach the half-open rule.
    if ($urandom_range(0, 3) == 0) e.py = vy[$urandom_range(0, n-1)];
    if ($urandom_range(0, 7) == 0) e.px = vx[$urandom_range(0, n-1)];
    for (int i = 0; i < n; i++) begin
      e.x0   = vx[i];
      e.y0   = vy[i];
      e.x1   = vx[(i+1) % n];
      e.y1   = vy[(i+1) % n];
      e.skip = ($urandom_range(0, 7) == 0);
      e.last = (i == n-1);
      if ($urandom_range(0, 15) == 0) begin
        e.px = rand_coord(sc);
        e.py = rand_coord(sc);
      end
      send_edge(e);
    end
  endtask

  initial begin
    edge_t e;
    int    n;
    // After reset the parity is clear, so a skipped last edge reports outside.
    add_row(0, 0, -ONE, -ONE, -ONE, ONE, 1, 1, 1, 0);
    // Unit square around the origin, point inside then outside.
    add_row(0, 0, -ONE, -ONE, ONE, -ONE, 0, 0);
    add_row(0, 0, ONE, -ONE, ONE, ONE, 0, 0);
    add_row(0, 0, ONE, ONE, -ONE, ONE, 0, 0);
    add_row(0, 0, -ONE, ONE, -ONE, -ONE, 0, 1);
    add_row(TWO, 0, -ONE, -ONE, ONE, -ONE, 0, 0);
    add_row(TWO, 0, ONE, -ONE, ONE, ONE, 0, 0);
    add_row(TWO, 0, ONE, ONE, -ONE, ONE, 0, 0);
    add_row(TWO, 0, -ONE, ONE, -ONE, -ONE, 0, 1);
    // A horizontal edge on the point's level never counts.
    add_row(0, 0, -ONE, 0, ONE, 0, 0, 1);
    // Point level with an upper vertex straddles; the next edge starts there.
    add_row(0, ONE, -ONE, -ONE, -ONE, ONE, 0, 0);
    add_row(0, ONE, -ONE, ONE, -ONE, TWO, 0, 1);
    // A crossing exactly at the point's x is not to its left.
    add_row(0, 0, 0, -ONE, 0, ONE, 0, 1);
    // A skipped last edge is ignored but still closes the polygon.
    add_row(0, 0, -ONE, -ONE, -ONE, ONE, 0, 0);
    add_row(0, 0, -TWO, -ONE, -TWO, ONE, 1, 1);
    // The point may move between edges of one polygon.
    add_row(0, 0, -ONE, -ONE, -ONE, ONE, 0, 0);
    add_row(-TWO, 0, -ONE, ONE, -ONE, -ONE, 0, 1);
    // Extremes of the coordinate range.
    add_row(CMAX, 0, CMIN, CMIN, CMIN, CMAX, 0, 1, 1, 1);
    add_row(CMAX, 0, CMIN, CMAX, CMIN, CMIN, 0, 1, 1, 1);
    add_row(CMIN, 0, CMIN, CMIN, CMIN, CMAX, 0, 1, 1, 0);
    add_row(0, 0, CMIN, CMIN, CMAX, CMAX, 0, 1);
    add_row(CMAX, CMIN, CMAX, CMAX, CMIN, CMIN, 0, 1);
    add_row(0, CMAX, -ONE, CMIN, -ONE, CMAX, 0, 1, 1, 1);
    add_row(0, CMIN, -ONE, CMIN, -ONE, CMAX, 0, 1, 1, 0);
    add_row(CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, 0, 1);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (edge_table[i]) send_edge(edge_table[i]);

    // Mostly closed polygons with random content, with some loose edges mixed in.
    while (edge_cnt < N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          e      = '{default: '0};
          e.px   = rand_coord(SC_FULL);
          e.py   = rand_coord(SC_FULL);
          e.x0   = rand_coord(SC_FULL);
          e.y0   = rand_coord(SC_FULL);
          e.x1   = rand_coord(SC_FULL);
          e.y1   = rand_coord(SC_FULL);
          e.skip = 1'($urandom_range(0, 1));
          e.last = 1'($urandom_range(0, 1));
          send_edge(e);
        end
      end else begin
        send_polygon();
      end
    end
    push <= 1'b0;

    while (inside_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Transferred %0d edges with %0d parity toggles; checked %0d inside results.",
             edge_cnt, toggle_cnt, result_cnt);
    if (err_cnt == 0) begin
      $display("point_in_polygon_parity_top regression: pass");
    end else begin
      $display("point_in_polygon_parity_top regression: fail");
    end
    $finish;
  end

endmodule
